>>> rtl/prgb_pkg.sv
// shared types and constants for the camera pixel unpacker
// no dependencies; imported by every module of the block
package prgb_pkg;

   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int MAX_HEIGHT_DEF = 2048;

   localparam int PIX_W   = 24;
   localparam int DEST_W  = 22;
   localparam int FMT_W   = 2;
   localparam int SIZE_W  = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   localparam logic [FMT_W-1:0] FMT_RGB565 = 2'd0;
   localparam logic [FMT_W-1:0] FMT_RGB555 = 2'd1;
   localparam logic [FMT_W-1:0] FMT_RGB24  = 2'd2;
   localparam logic [FMT_W-1:0] FMT_GREY   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_FORMAT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIRROR        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT  = 2'd3;

   localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = 12'd640;
   localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = 12'd480;

   typedef struct packed {
      logic [FMT_W-1:0]  source_format;
      logic              mirror;
      logic [SIZE_W-1:0] frame_width;
      logic [SIZE_W-1:0] frame_height;
   } cfg_type;

endpackage

>>> rtl/pixel_unpack_to_rgb32_mirror.sv
// Camera pixel unpacker: converts one RGB565, RGB555, RGB24 or grey pixel
// per transfer into a 0xRRGGBB word with its raster destination index,
// optionally mirrored per row, and flags the last pixel of each frame. It
// takes one pixel every clock cycle while the output is not stalled; each
// result is in the output register in the cycle after its pixel is taken
// and the input stays ready whenever that register is empty or being
// drained in the same cycle. Configuration writes take effect on the next
// pixel and never reset the raster counters.
// depends on prgb_pkg, prgb_decode, prgb_addr
module pixel_unpack_to_rgb32_mirror #(
   parameter int MAX_WIDTH  = prgb_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = prgb_pkg::MAX_HEIGHT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [prgb_pkg::PIX_W-1:0]      req_pixel_word,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [prgb_pkg::PIX_W-1:0]      rsp_rgb_pixel,
   output logic [prgb_pkg::DEST_W-1:0]     rsp_dest_index,
   output logic                            rsp_frame_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [prgb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [prgb_pkg::CSR_DATA_W-1:0] csr_data
);
   import prgb_pkg::*;

   cfg_type cfg_ff, cfg_in;

   logic              valid_ff, valid_in;
   logic [PIX_W-1:0]  rgb_ff;
   logic [DEST_W-1:0] dest_ff;
   logic              last_ff;

   logic              take;
   logic [PIX_W-1:0]  rgb;
   logic [DEST_W-1:0] dest;
   logic              last;

   assign csr_ready = 1'b1;
   assign req_ready = !valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SOURCE_FORMAT: cfg_in.source_format = csr_data[FMT_W-1:0];
            CSR_MIRROR:        cfg_in.mirror        = csr_data[0];
            CSR_FRAME_WIDTH:   cfg_in.frame_width   = csr_data[SIZE_W-1:0];
            CSR_FRAME_HEIGHT:  cfg_in.frame_height  = csr_data[SIZE_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   prgb_decode u_decode (
      .source_format (cfg_ff.source_format),
      .pixel_word    (req_pixel_word),
      .rgb_pixel     (rgb)
   );

   prgb_addr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_addr (
      .clock      (clock),
      .reset      (reset),
      .advance    (take),
      .cfg        (cfg_ff),
      .dest_index (dest),
      .frame_last (last)
   );

   assign valid_in = take || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cfg_ff   <= '{source_format: FMT_RGB565, mirror: 1'b0,
                       frame_width: FRAME_WIDTH_RST, frame_height: FRAME_HEIGHT_RST};
      end else begin
         valid_ff <= valid_in;
         cfg_ff   <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rgb_ff  <= rgb;
         dest_ff <= dest;
         last_ff <= last;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_rgb_pixel  = rgb_ff;
   assign rsp_dest_index = dest_ff;
   assign rsp_frame_last = last_ff;

endmodule

>>> rtl/prgb_decode.sv
// pixel format decoder: raw camera word to 0xRRGGBB
// depends on prgb_pkg
module prgb_decode (
   input  logic [prgb_pkg::FMT_W-1:0] source_format,
   input  logic [prgb_pkg::PIX_W-1:0] pixel_word,
   output logic [prgb_pkg::PIX_W-1:0] rgb_pixel
);
   import prgb_pkg::*;

   always_comb begin
      case (source_format)
         FMT_RGB565: begin
            rgb_pixel = {pixel_word[15:11], 3'b000, pixel_word[10:5], 2'b00,
                         pixel_word[4:0], 3'b000};
         end
         FMT_RGB555: begin
            rgb_pixel = {pixel_word[14:10], 3'b000, pixel_word[9:5], 3'b000,
                         pixel_word[4:0], 3'b000};
         end
         FMT_RGB24: begin
            rgb_pixel = pixel_word;
         end
         FMT_GREY: begin
            rgb_pixel = {pixel_word[7:0], pixel_word[7:0], pixel_word[7:0]};
         end
         default: begin
            rgb_pixel = pixel_word;
         end
      endcase
   end

endmodule

>>> rtl/prgb_addr.sv
// raster position counters and destination index with optional mirror
// depends on prgb_pkg
module prgb_addr #(
   parameter int MAX_WIDTH  = prgb_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = prgb_pkg::MAX_HEIGHT_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  prgb_pkg::cfg_type           cfg,
   output logic [prgb_pkg::DEST_W-1:0] dest_index,
   output logic                        frame_last
);
   import prgb_pkg::*;

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int RW   = $clog2(MAX_HEIGHT);
   localparam int WCLG = $clog2(MAX_WIDTH + 1);
   localparam int HCLG = $clog2(MAX_HEIGHT + 1);
   localparam int WSW  = (WCLG > SIZE_W) ? WCLG : SIZE_W;
   localparam int HSW  = (HCLG > SIZE_W) ? HCLG : SIZE_W;

   logic [CW-1:0]     col_ff, col_in;
   logic [RW-1:0]     row_ff, row_in;
   logic [DEST_W-1:0] base_ff, base_in;

   logic [WSW-1:0] fw_ext, w_cl;
   logic [HSW-1:0] fh_ext, h_cl;
   logic [CW-1:0]  wm1, col, xcol;
   logic [RW-1:0]  hm1, row;
   logic           last_col, last_row;

   always_comb begin
      fw_ext = WSW'(cfg.frame_width);
      fh_ext = HSW'(cfg.frame_height);
      if (fw_ext == '0) begin
         w_cl = WSW'(1);
      end else if (fw_ext > WSW'(MAX_WIDTH)) begin
         w_cl = WSW'(MAX_WIDTH);
      end else begin
         w_cl = fw_ext;
      end
      if (fh_ext == '0) begin
         h_cl = HSW'(1);
      end else if (fh_ext > HSW'(MAX_HEIGHT)) begin
         h_cl = HSW'(MAX_HEIGHT);
      end else begin
         h_cl = fh_ext;
      end
      wm1 = CW'(w_cl - WSW'(1));
      hm1 = RW'(h_cl - HSW'(1));
      col = (col_ff > wm1) ? wm1 : col_ff;
      row = (row_ff > hm1) ? hm1 : row_ff;
      last_col = (col == wm1);
      last_row = (row == hm1);
      xcol = cfg.mirror ? (wm1 - col) : col;
      dest_index = base_ff + DEST_W'(xcol);
      frame_last = last_col && last_row;
   end

   // counter update for the next pixel
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      base_in = base_ff;
      if (advance) begin
         if (last_col) begin
            col_in = '0;
            if (last_row) begin
               row_in  = '0;
               base_in = '0;
            end else begin
               row_in  = row + RW'(1);
               base_in = base_ff + DEST_W'(w_cl);
            end
         end else begin
            col_in = col + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         base_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         base_ff <= base_in;
      end
   end

endmodule

>>> rtl/prgb_checker.sv
// port-level checker for the pixel unpacker, bound to the top level
// depends on prgb_pkg and pixel_unpack_to_rgb32_mirror
module prgb_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [prgb_pkg::PIX_W-1:0]      rsp_rgb_pixel,
   input logic [prgb_pkg::DEST_W-1:0]     rsp_dest_index,
   input logic                            rsp_frame_last
);
   import prgb_pkg::*;

   // result register empty after reset
   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("result valid right after reset");

   // every accepted pixel shows a result next cycle
   a_take_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("accepted pixel gave no result");

   // no new pixel while a stalled result occupies the register
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("input ready while result stalled");

   // stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_rgb_pixel) && $stable(rsp_dest_index)
          && $stable(rsp_frame_last)))
      else $error("stalled result changed");

endmodule

bind pixel_unpack_to_rgb32_mirror prgb_checker u_prgb_checker (.*);
